[design/tmad_pkg.sv]
`default_nettype none

package tmad_pkg;

  // Defaults and fixed field widths.
  localparam int COLUMN_BITS_DEFAULT = 10;
  localparam int CHAR_W = 8;
  localparam int LVL_W = 8;
  localparam int COL_W = 10;
  localparam int ALT_W = 4;
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_HIGH_BIT = 1'b1;

  // Reset value of the alternate color register.
  localparam logic [ALT_W-1:0] ALT_COLOR_RESET = 4'd2;

  // Escape characters, seven bits; letters are compared in lower case.
  localparam logic [6:0] CARET = 7'h5E;
  localparam logic [6:0] CASE_BIT = 7'h20;
  localparam logic [6:0] ESC_CHAR_RESET = 7'h72;
  localparam logic [6:0] ESC_CHAR_BOLD = 7'h62;
  localparam logic [6:0] ESC_CHAR_SHADOW = 7'h73;
  localparam logic [6:0] ESC_CHAR_ITALIC = 7'h69;
  localparam logic [6:0] ESC_CHAR_ALT = 7'h61;
  localparam logic [6:0] DIGIT_LO = 7'h30;
  localparam logic [6:0] DIGIT_HI = 7'h39;

  // Color levels used by the palette.
  localparam logic [LVL_W-1:0] LVL_FULL = 8'd255;
  localparam logic [LVL_W-1:0] LVL_GRAY = 8'd155;
  localparam logic [LVL_W-1:0] LVL_ORANGE = 8'd135;
  localparam logic [LVL_W-1:0] LVL_NONE = 8'd0;

  typedef enum logic [2:0] {
    ESC_NONE,
    ESC_RESET,
    ESC_BOLD,
    ESC_SHADOW,
    ESC_ITALIC,
    ESC_ALT,
    ESC_DIGIT
  } esc_op_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_t;

  localparam rgb_t WHITE = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_FULL};

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    rgb_t              color;
    logic              italic_on;
    logic              shadow_on;
    logic [COL_W-1:0]  column;
    logic              string_done;
    logic              run_last;
  } result_t;

  // Ten entry palette; indexes ten and up give white.
  function automatic rgb_t palette(input logic [ALT_W-1:0] idx);
    rgb_t c;
    c = WHITE;
    unique case (idx)
      4'd0: c = '{red: LVL_GRAY, green: LVL_GRAY, blue: LVL_GRAY};
      4'd1: c = '{red: LVL_FULL, green: LVL_NONE, blue: LVL_NONE};
      4'd2: c = '{red: LVL_NONE, green: LVL_FULL, blue: LVL_NONE};
      4'd3: c = '{red: LVL_FULL, green: LVL_FULL, blue: LVL_NONE};
      4'd4: c = '{red: LVL_NONE, green: LVL_NONE, blue: LVL_FULL};
      4'd5: c = '{red: LVL_NONE, green: LVL_FULL, blue: LVL_FULL};
      4'd6: c = '{red: LVL_FULL, green: LVL_NONE, blue: LVL_FULL};
      4'd7: c = WHITE;
      4'd8: c = '{red: LVL_NONE, green: LVL_NONE, blue: LVL_NONE};
      4'd9: c = '{red: LVL_FULL, green: LVL_ORANGE, blue: LVL_NONE};
      default: c = WHITE;
    endcase
    return c;
  endfunction

  // Classifies the byte that follows a caret, bit 7 already stripped.
  function automatic esc_op_t esc_decode(input logic [6:0] m);
    esc_op_t op;
    logic [6:0] lower;
    op = ESC_NONE;
    lower = m | CASE_BIT;
    if (m >= DIGIT_LO && m <= DIGIT_HI) begin
      op = ESC_DIGIT;
    end else if (lower == ESC_CHAR_RESET) begin
      op = ESC_RESET;
    end else if (lower == ESC_CHAR_BOLD) begin
      op = ESC_BOLD;
    end else if (lower == ESC_CHAR_SHADOW) begin
      op = ESC_SHADOW;
    end else if (lower == ESC_CHAR_ITALIC) begin
      op = ESC_ITALIC;
    end else if (lower == ESC_CHAR_ALT) begin
      op = ESC_ALT;
    end
    return op;
  endfunction

  // One drawn character. The returned color is also the new current color.
  function automatic result_t draw_char(
    input logic [CHAR_W-1:0] raw,
    input logic              done,
    input logic              applied,
    input logic              bold,
    input logic              alt_high_bit,
    input rgb_t              cur,
    input logic [ALT_W-1:0]  alt_color,
    input logic              italic,
    input logic              shadow,
    input logic [COL_W-1:0]  column
  );
    result_t r;
    logic [CHAR_W-1:0] c;
    rgb_t color;
    c = raw;
    color = cur;
    if (bold || (!applied && alt_high_bit)) begin
      c[CHAR_W-1] = ~c[CHAR_W-1];
    end
    if (!applied) begin
      if (c[CHAR_W-1]) begin
        color = palette(alt_color);
        if (color != WHITE) begin
          c[CHAR_W-1] = 1'b0;
        end
      end else begin
        color = WHITE;
      end
    end
    r.char_code = c;
    r.color = color;
    r.italic_on = italic;
    r.shadow_on = shadow;
    r.column = column;
    r.string_done = done;
    r.run_last = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/tmad_attr.sv]
`default_nettype none

module tmad_attr #(
  parameter int COLUMN_BITS = tmad_pkg::COLUMN_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [tmad_pkg::CHAR_W-1:0] byte_value,
  input  wire logic                       end_of_string,
  input  wire logic [tmad_pkg::ALT_W-1:0] alt_color,
  input  wire logic                       alt_high_bit,
  output logic [1:0]                      n_results,
  output tmad_pkg::result_t               res_a,
  output tmad_pkg::result_t               res_b
);
  import tmad_pkg::*;

  localparam logic [COLUMN_BITS-1:0] CNT_MAX = {COLUMN_BITS{1'b1}};

  logic                   escape_pending, escape_pending_next;
  logic                   esc_high, esc_high_next;
  rgb_t                   cur, cur_next;
  logic                   bold_flag, bold_flag_next;
  logic                   shadow_flag, shadow_flag_next;
  logic                   italic_flag, italic_flag_next;
  logic                   escape_applied, escape_applied_next;
  logic [COLUMN_BITS-1:0] cell_count, cell_count_next;

  logic [6:0]             m;
  logic                   is_caret;
  esc_op_t                op;
  logic [COLUMN_BITS-1:0] cnt1, cnt2;
  result_t                d_main, d_open, d_tail, d_alone;

  always_comb begin
    m = byte_value[6:0];
    is_caret = (m == CARET);
    op = esc_decode(m);
    cnt1 = (cell_count == CNT_MAX) ? cell_count : cell_count + COLUMN_BITS'(1);
    cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + COLUMN_BITS'(1);

    // Plain character with the current attributes.
    d_main = draw_char(byte_value, end_of_string, escape_applied, bold_flag, alt_high_bit,
                       cur, alt_color, italic_flag, shadow_flag, COL_W'(cell_count));
    // Failed escape: the opening caret, then the byte, both as if no escape applied.
    d_open = draw_char({esc_high, CARET}, 1'b0, 1'b0, bold_flag, alt_high_bit,
                       cur, alt_color, italic_flag, shadow_flag, COL_W'(cell_count));
    d_tail = draw_char(byte_value, end_of_string, 1'b0, bold_flag, alt_high_bit,
                       cur, alt_color, italic_flag, shadow_flag, COL_W'(cnt1));
    // A caret that ends the string is drawn alone.
    d_alone = draw_char(byte_value, 1'b1, 1'b0, bold_flag, alt_high_bit,
                        cur, alt_color, italic_flag, shadow_flag, COL_W'(cell_count));

    escape_pending_next = escape_pending;
    esc_high_next = esc_high;
    cur_next = cur;
    bold_flag_next = bold_flag;
    shadow_flag_next = shadow_flag;
    italic_flag_next = italic_flag;
    escape_applied_next = escape_applied;
    cell_count_next = cell_count;
    n_results = 2'd0;
    res_a = d_main;
    res_b = d_tail;

    if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (is_caret) begin
        n_results = 2'd1;
        cur_next = d_main.color;
        cell_count_next = cnt1;
      end else if (op != ESC_NONE) begin
        escape_applied_next = 1'b1;
        unique case (op)
          ESC_RESET: begin
            cur_next = WHITE;
            bold_flag_next = 1'b0;
            shadow_flag_next = 1'b0;
            italic_flag_next = 1'b0;
          end
          ESC_BOLD:   bold_flag_next = ~bold_flag;
          ESC_SHADOW: shadow_flag_next = ~shadow_flag;
          ESC_ITALIC: italic_flag_next = ~italic_flag;
          ESC_ALT:    cur_next = palette(alt_color);
          ESC_DIGIT:  cur_next = palette(m[ALT_W-1:0]);
          default: ;
        endcase
      end else begin
        escape_applied_next = 1'b0;
        n_results = 2'd2;
        res_a = d_open;
        cur_next = d_tail.color;
        cell_count_next = cnt2;
      end
    end else if (is_caret) begin
      if (end_of_string) begin
        escape_applied_next = 1'b0;
        n_results = 2'd1;
        res_a = d_alone;
        cur_next = d_alone.color;
        cell_count_next = cnt1;
      end else begin
        escape_pending_next = 1'b1;
        esc_high_next = byte_value[CHAR_W-1];
      end
    end else begin
      n_results = 2'd1;
      cur_next = d_main.color;
      cell_count_next = cnt1;
    end

    if (n_results == 2'd1) begin
      res_a.run_last = 1'b1;
    end
    res_b.run_last = 1'b1;

    if (end_of_string) begin
      escape_pending_next = 1'b0;
      esc_high_next = 1'b0;
      cur_next = WHITE;
      bold_flag_next = 1'b0;
      shadow_flag_next = 1'b0;
      italic_flag_next = 1'b0;
      escape_applied_next = 1'b0;
      cell_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      esc_high <= 1'b0;
      cur <= WHITE;
      bold_flag <= 1'b0;
      shadow_flag <= 1'b0;
      italic_flag <= 1'b0;
      escape_applied <= 1'b0;
      cell_count <= '0;
    end else if (fire) begin
      escape_pending <= escape_pending_next;
      esc_high <= esc_high_next;
      cur <= cur_next;
      bold_flag <= bold_flag_next;
      shadow_flag <= shadow_flag_next;
      italic_flag <= italic_flag_next;
      escape_applied <= escape_applied_next;
      cell_count <= cell_count_next;
    end
  end

`ifndef SYNTHESIS
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_string |=> !escape_pending && !escape_applied && cell_count == '0)
    else $error("string state not cleared after final byte");

  a_draw_counts: assert property (@(posedge clk) disable iff (rst)
    fire && !end_of_string && n_results != 2'd0 |=> cell_count != '0)
    else $error("column counter did not advance after a drawn character");
`endif

endmodule

`default_nettype wire

[design/tmad_out_q.sv]
`default_nettype none

module tmad_out_q (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        push_count,
  input  wire tmad_pkg::result_t push_a,
  input  wire tmad_pkg::result_t push_b,
  input  wire logic              pop,
  output logic                   out_valid,
  output tmad_pkg::result_t      out_item,
  output logic [1:0]             free_slots
);
  import tmad_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  result_t    slots [2];
  result_t    slots_next [2];
  logic [1:0] count, count_next;
  logic [1:0] after_pop;

  always_comb begin
    after_pop = count - {1'b0, pop};
    slots_next[0] = slots[0];
    slots_next[1] = slots[1];
    if (pop) begin
      slots_next[0] = slots[1];
    end
    if (push_count != 2'd0) begin
      slots_next[after_pop[0]] = push_a;
    end
    if (push_count == 2'd2) begin
      slots_next[1] = push_b;
    end
    count_next = after_pop + push_count;
  end

  assign out_valid = (count != 2'd0);
  assign out_item = slots[0];
  assign free_slots = DEPTH - count;

  always_ff @(posedge clk) begin
    slots[0] <= slots_next[0];
    slots[1] <= slots_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH)
    else $error("output queue holds more items than slots");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(out_item))
    else $error("waiting result changed before it was taken");
`endif

endmodule

`default_nettype wire

[design/text_markup_attribute_decoder_core.sv]
`default_nettype none

// Text markup attribute decoder. Each input item carries one byte of a text
// string (s_tdata) and a flag on the string's final byte (s_tlast). The block
// turns the bytes into characters with color, italic and shadow attributes:
// a '^' opens an escape whose next byte resets attributes, toggles bold,
// shadow or italic, picks a palette color or the alternate color, and "^^"
// draws a literal caret. An unknown escape draws the caret and then the byte,
// so that input item gives two result items; a known escape gives none.
// The block takes one item per clock while the output queue has room for
// its results. An item is registered on input, decoded by one level of
// logic against the attribute state and written into a two-slot output
// queue, whose head is offered on the result stream.
// An item that gives two results waits for an empty output queue. The two
// configuration registers (alternate color, high-bit flip) are to be written
// by the user only while the block is idle; the block does not enforce this.
// Both survive the end of a string, which clears escape and attribute state.
module text_markup_attribute_decoder_core #(
  parameter int COLUMN_BITS = tmad_pkg::COLUMN_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [tmad_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] byte_value
  input  wire logic                            s_tlast,   // end_of_string
  // Result stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [7:0] char_code, [15:8] red_level, [23:16] green_level,
  // [31:24] blue_level, [32] italic_on, [33] shadow_on, [43:34] column,
  // [47:44] zero
  output logic [tmad_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                 m_tlast,   // run_last
  output logic                                 m_tuser,   // string_done
  // Configuration write port.
  input  wire logic                            cfg_write,
  input  wire logic [tmad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmad_pkg::*;

  // Configuration registers.
  logic [ALT_W-1:0]  alt_color;
  logic              alt_high_bit;

  // Input register.
  logic              in_valid;
  logic [CHAR_W-1:0] in_byte;
  logic              in_eos;

  logic              fire;
  logic [1:0]        n_results;
  logic [1:0]        free_slots;
  result_t           res_a, res_b;
  logic              out_valid;
  result_t           out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_color <= ALT_COLOR_RESET;
      alt_high_bit <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ALT_COLOR:    alt_color <= cfg_data[ALT_W-1:0];
        CFG_ALT_HIGH_BIT: alt_high_bit <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held item is decoded once the queue has room for all its results.
  // The room check looks only at the queue fill, so the result side's
  // ready never reaches the input side's ready.
  assign fire = in_valid && (n_results <= free_slots);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[CHAR_W-1:0];
      in_eos <= s_tlast;
    end
  end

  tmad_attr #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_attr (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .byte_value   (in_byte),
    .end_of_string(in_eos),
    .alt_color    (alt_color),
    .alt_high_bit (alt_high_bit),
    .n_results    (n_results),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  tmad_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push_count(fire ? n_results : 2'd0),
    .push_a    (res_a),
    .push_b    (res_b),
    .pop       (m_tvalid && m_tready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .free_slots(free_slots)
  );

  assign m_tvalid = out_valid;
  assign m_tdata = {4'b0000, out_item.column, out_item.shadow_on, out_item.italic_on,
                    out_item.color.blue, out_item.color.green, out_item.color.red,
                    out_item.char_code};
  assign m_tlast = out_item.run_last;
  assign m_tuser = out_item.string_done;

`ifndef SYNTHESIS
  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_byte) && $stable(in_eos))
    else $error("held input item lost before decode");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("final character of a string not marked as last of its item");
`endif

endmodule

`default_nettype wire
